// ===== design/sff_pkg.sv =====
// ----------------------------------------------------------------------------
// sff_pkg
// Shared types and constants for the spike flatten filter.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned MAX_WIDTH  = 63;
  localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
  localparam int unsigned CW_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WIDTH_W    = 6;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned SUM_W      = PIX_W + 3;
  localparam int unsigned DIV_K      = SUM_W + 2;
  localparam int unsigned REC_W      = DIV_K;
  localparam int unsigned PROD_W     = SUM_W + REC_W;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [REC_W-1:0]   REC3 = REC_W'(((2 ** DIV_K) + 2) / 3);
  localparam logic [REC_W-1:0]   REC5 = REC_W'(((2 ** DIV_K) + 4) / 5);
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(30);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH,
    CFG_SPIKE_THRESHOLD
  } cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_SUM,
    B_DIV
  } back_state_e;

  typedef struct packed {
    logic [7:0] pixel_in;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pix;
    logic              flush;
    logic              emit;
    logic              has_above;
    logic              was_first;
    logic [CW_W-1:0]   width;
    logic [ADDR_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic              orig_we;
    logic              upd_we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  orig_wdata;
    logic [PIX_W-1:0]  upd_wdata;
    logic [ADDR_W-1:0] self_addr;
    logic [ADDR_W-1:0] right_addr;
  } ram_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] self_pix;
    logic [PIX_W-1:0] right_pix;
    logic [PIX_W-1:0] above_pix;
  } ram_rsp_t;

endpackage

// ===== design/sff_ram.sv =====
// ----------------------------------------------------------------------------
// sff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/sff_front.sv =====
// ----------------------------------------------------------------------------
// sff_front
// Accepts pixels, tracks raster position and issues work commands.
// ----------------------------------------------------------------------------
module sff_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sff_pkg::in_t                   in_data_i,
  input  logic [sff_pkg::WIDTH_W-1:0]    image_width_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output sff_pkg::cmd_t                  cmd_o
);
  import sff_pkg::*;

  logic [ADDR_W-1:0] col_cnt_q, col_cnt_d;
  logic              first_row_q, first_row_d;
  logic              has_above_q, has_above_d;
  logic [CW_W-1:0]   live_w;
  logic [ADDR_W-1:0] col;
  logic              row_done;
  logic              flush;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    if (image_width_i == '0) begin
      live_w = CW_W'(1);
    end else if ((WIDTH_W + 1)'(image_width_i) > (WIDTH_W + 1)'(MAX_WIDTH)) begin
      live_w = CW_W'(MAX_WIDTH);
    end else begin
      live_w = CW_W'(image_width_i);
    end
  end

  always_comb begin
    if (CW_W'(col_cnt_q) >= live_w) begin
      col = ADDR_W'(live_w - CW_W'(1));
    end else begin
      col = col_cnt_q;
    end
  end

  assign row_done = (CW_W'(col) + CW_W'(1)) >= live_w;
  assign flush    = in_data_i.frame_end && row_done;

  always_comb begin
    cmd_o.pix       = in_data_i.pixel_in[PIX_W-1:0];
    cmd_o.flush     = flush;
    cmd_o.emit      = !first_row_q;
    cmd_o.has_above = has_above_q;
    cmd_o.was_first = first_row_q;
    cmd_o.width     = live_w;
    cmd_o.col       = col;
  end

  always_comb begin
    col_cnt_d   = col_cnt_q;
    first_row_d = first_row_q;
    has_above_d = has_above_q;
    if (push_o) begin
      if (flush) begin
        col_cnt_d   = '0;
        first_row_d = 1'b1;
        has_above_d = 1'b0;
      end else if (row_done) begin
        col_cnt_d = '0;
        if (first_row_q) begin
          first_row_d = 1'b0;
        end else begin
          has_above_d = 1'b1;
        end
      end else begin
        col_cnt_d = col + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      first_row_q <= 1'b1;
      has_above_q <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      first_row_q <= first_row_d;
      has_above_q <= has_above_d;
    end
  end

endmodule

// ===== design/sff_fifo.sv =====
// ----------------------------------------------------------------------------
// sff_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module sff_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sff_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output sff_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);
  import sff_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o  = count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (FIFO_PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FIFO_PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/sff_back.sv =====
// ----------------------------------------------------------------------------
// sff_back
// Executes commands: neighbor compare, average, row store and frame flush.
// ----------------------------------------------------------------------------
module sff_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sff_pkg::THR_W-1:0]   threshold_i,
  input  logic                        fifo_empty_i,
  input  sff_pkg::cmd_t               fifo_cmd_i,
  output logic                        pop_o,
  output sff_pkg::ram_req_t           ram_req_o,
  input  sff_pkg::ram_rsp_t           ram_rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output sff_pkg::out_t               out_data_o
);
  import sff_pkg::*;

  function automatic logic join_nb(logic [PIX_W-1:0] self_v, logic [PIX_W-1:0] nb,
                                   logic present, logic [THR_W-1:0] thr);
    logic [PIX_W-1:0] diff;
    diff = self_v - nb;
    return present && (self_v > nb) && (SUM_W'(diff) > SUM_W'(thr));
  endfunction

  back_state_e       state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              flushing_q, flushing_d;
  logic [PIX_W-1:0]  left_q, left_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              slot_free;
  logic              flush_last;
  logic              right_ok;
  logic              above_ok;
  logic              j_left, j_right, j_above, j_below;
  logic [REC_W-1:0]  rec;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  quot;
  logic [PIX_W-1:0]  result;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign flush_last = (CW_W'(idx_q) + CW_W'(1)) == cmd_q.width;
  assign right_ok   = (CW_W'(idx_q) + CW_W'(1)) < cmd_q.width;
  assign above_ok   = flushing_q ? !cmd_q.was_first : cmd_q.has_above;

  assign j_left  = join_nb(ram_rsp_i.self_pix, left_q, idx_q != '0, threshold_i);
  assign j_right = join_nb(ram_rsp_i.self_pix, ram_rsp_i.right_pix, right_ok, threshold_i);
  assign j_above = join_nb(ram_rsp_i.self_pix, ram_rsp_i.above_pix, above_ok, threshold_i);
  assign j_below = join_nb(ram_rsp_i.self_pix, cmd_q.pix, !flushing_q, threshold_i);

  always_comb begin
    sum_d = SUM_W'(ram_rsp_i.self_pix)
          + (j_left  ? SUM_W'(left_q)              : '0)
          + (j_right ? SUM_W'(ram_rsp_i.right_pix) : '0)
          + (j_above ? SUM_W'(ram_rsp_i.above_pix) : '0)
          + (j_below ? SUM_W'(cmd_q.pix)           : '0);
    cnt_d = CNT_W'(1) + CNT_W'(j_left) + CNT_W'(j_right) + CNT_W'(j_above) + CNT_W'(j_below);
  end

  // reciprocal multiply for counts 3 and 5, shifts otherwise
  assign rec  = (cnt_q == CNT_W'(3)) ? REC3 : REC5;
  assign prod = PROD_W'(sum_q) * PROD_W'(rec);

  always_comb begin
    case (cnt_q)
      CNT_W'(2): quot = sum_q >> 1;
      CNT_W'(3): quot = prod[DIV_K +: SUM_W];
      CNT_W'(4): quot = sum_q >> 2;
      CNT_W'(5): quot = prod[DIV_K +: SUM_W];
      default:   quot = sum_q;
    endcase
  end

  assign result = quot[PIX_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = B_READ;
        end
      end
      B_READ: state_d = B_SUM;
      B_SUM: begin
        if (flushing_q || cmd_q.emit) begin
          state_d = B_DIV;
        end else if (cmd_q.flush) begin
          state_d = B_READ;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_DIV: begin
        if (slot_free) begin
          if (flushing_q) begin
            state_d = flush_last ? B_IDLE : B_READ;
          end else begin
            state_d = cmd_q.flush ? B_READ : B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop_o                = 1'b0;
    cmd_d                = cmd_q;
    idx_d                = idx_q;
    flushing_d           = flushing_q;
    left_d               = left_q;
    out_d                = out_q;
    out_valid_d          = out_valid_q && !out_ready_i;
    ram_req_o.orig_we    = 1'b0;
    ram_req_o.upd_we     = 1'b0;
    ram_req_o.waddr      = idx_q;
    ram_req_o.orig_wdata = cmd_q.pix;
    ram_req_o.upd_wdata  = result;
    ram_req_o.self_addr  = idx_q;
    ram_req_o.right_addr = (idx_q == ADDR_W'(MAX_WIDTH - 1)) ? idx_q : idx_q + ADDR_W'(1);
    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o = 1'b1;
          cmd_d = fifo_cmd_i;
          idx_d = fifo_cmd_i.col;
        end
      end
      B_READ: ;
      B_SUM: begin
        if (!flushing_q) begin
          ram_req_o.orig_we = 1'b1;
          if (!cmd_q.emit && cmd_q.flush) begin
            flushing_d = 1'b1;
            idx_d      = '0;
          end
        end
      end
      B_DIV: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.pixel_out = result;
          left_d          = result;
          if (flushing_q) begin
            out_d.run_last = flush_last;
            if (flush_last) begin
              flushing_d = 1'b0;
              left_d     = '0;
            end else begin
              idx_d = idx_q + ADDR_W'(1);
            end
          end else begin
            out_d.run_last   = !cmd_q.flush;
            ram_req_o.upd_we = 1'b1;
            if (cmd_q.flush) begin
              flushing_d = 1'b1;
              idx_d      = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    out_q <= out_d;
    if (state_q == B_SUM) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      flushing_q  <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      flushing_q  <= flushing_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/spike_flatten_filter.sv =====
// ----------------------------------------------------------------------------
// spike_flatten_filter
// Raster-scan spike flattener: cross-neighbor average of low neighbors.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready) in row-major order, with
// frame_end set on the last pixel of the frame. Each pixel of row r+1 releases
// the flattened pixel of row r in the same column on the out channel; the last
// pixel of the frame also releases the whole last row. run_last marks the last
// result a transaction produces. image_width and spike_threshold are written
// through the cfg port; the user must do so only while the block is idle, which
// the block does not enforce. A front stage takes one pixel per cycle into a
// 4-entry command queue while the queue is not full. The back stage takes a
// command only when idle and handles an emitting pixel as queue pop, RAM read,
// compare/sum and divide, a first-row pixel, which emits nothing, as pop, read
// and compare/sum, and a flushed result as read, compare/sum and divide; the
// registered RAM read and the sum-then-divide split set these steps.
// Reset clears the raster position and the output valid flag; the row RAMs
// hold no reset value and are written before use. When the receiver stalls,
// the result waits in the output register, the back stage holds, and the
// front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module spike_flatten_filter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  sff_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output sff_pkg::out_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic [sff_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sff_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sff_pkg::*;

  logic [WIDTH_W-1:0] width_q;
  logic [THR_W-1:0]   thr_q;
  logic               fifo_full;
  logic               fifo_empty;
  logic               push;
  logic               pop;
  cmd_t               push_cmd;
  cmd_t               head_cmd;
  ram_req_t           ram_req;
  ram_rsp_t           ram_rsp;
  logic [PIX_W-1:0]   self_rdata;
  logic [PIX_W-1:0]   right_rdata;
  logic [PIX_W-1:0]   above_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
      thr_q   <= THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:     width_q <= cfg_data_i[WIDTH_W-1:0];
        CFG_SPIKE_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  sff_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .image_width_i (width_q),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  sff_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  sff_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .threshold_i  (thr_q),
    .fifo_empty_i (fifo_empty),
    .fifo_cmd_i   (head_cmd),
    .pop_o        (pop),
    .ram_req_o    (ram_req),
    .ram_rsp_i    (ram_rsp),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // original row, two copies for self and right reads
  sff_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_orig_self (
    .clk_i   (clk_i),
    .we_i    (ram_req.orig_we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.orig_wdata),
    .raddr_i (ram_req.self_addr),
    .rdata_o (self_rdata)
  );

  sff_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_orig_right (
    .clk_i   (clk_i),
    .we_i    (ram_req.orig_we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.orig_wdata),
    .raddr_i (ram_req.right_addr),
    .rdata_o (right_rdata)
  );

  // flattened row above
  sff_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upd_row (
    .clk_i   (clk_i),
    .we_i    (ram_req.upd_we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.upd_wdata),
    .raddr_i (ram_req.self_addr),
    .rdata_o (above_rdata)
  );

  always_comb begin
    ram_rsp.self_pix  = self_rdata;
    ram_rsp.right_pix = right_rdata;
    ram_rsp.above_pix = above_rdata;
  end

  a_ram_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.orig_we || ram_req.upd_we) |-> (int'(ram_req.waddr) < MAX_WIDTH))
    else $error("row RAM write beyond row length");

  a_cmd_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (CW_W'(push_cmd.col) < push_cmd.width))
    else $error("command column outside live width");

  a_cmd_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (push_cmd.width != '0 && int'(push_cmd.width) <= MAX_WIDTH))
    else $error("command width out of range");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for spike_flatten_filter. A driver feeds raster frames
// from a queue, a monitor compares every output transaction against a
// predictor of the cross-neighbor flattening. Several width/threshold settings
// are exercised, including the width extremes, with random idling on both
// sides and one long receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import sff_pkg::*;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  spike_flatten_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_t          raster_q[$];
  out_t         flat_q[$];
  int unsigned  n_items    = 0;
  int unsigned  n_mismatch = 0;
  int unsigned  src_gap    = 0;
  int unsigned  sink_gap   = 0;
  logic         quiet      = 1'b0;
  logic         long_hold  = 1'b0;
  bit           hold_go    = 1'b0;

  // predictor state
  logic [7:0]   upd_row  [MAX_WIDTH];
  logic [7:0]   orig_row [MAX_WIDTH];
  logic [7:0]   left_px     = '0;
  int unsigned  col_cnt     = 0;
  bit           first_row_q = 1'b1;
  bit           has_above_q = 1'b0;
  logic [5:0]   cfg_width   = WIDTH_RESET;
  logic [7:0]   cfg_thr     = THR_RESET;

  function automatic void join_low(input logic [7:0] self_v, input logic [7:0] nb,
                                   input bit present, inout int unsigned sum,
                                   inout int unsigned cnt);
    if (present && self_v > nb && (self_v - nb) > cfg_thr) begin
      sum += 32'(nb);
      cnt++;
    end
  endfunction

  function automatic logic [7:0] flatten_px(input int unsigned col, input int unsigned w,
                                            input bit above_ok, input bit below_ok,
                                            input logic [7:0] below);
    int unsigned sum;
    int unsigned cnt;
    logic [7:0]  self_v;
    self_v = orig_row[col];
    sum = 32'(self_v);
    cnt = 1;
    join_low(self_v, left_px, col > 0, sum, cnt);
    join_low(self_v, (col + 1 < w) ? orig_row[col + 1] : 8'd0, col + 1 < w, sum, cnt);
    join_low(self_v, upd_row[col], above_ok, sum, cnt);
    join_low(self_v, below, below_ok, sum, cnt);
    return 8'(sum / cnt);
  endfunction

  function automatic void predict_pixel(input in_t t);
    int unsigned w;
    int unsigned c;
    bit          was_first;
    bit          row_done;
    logic [7:0]  r;
    out_t        run[$];
    out_t        o;
    w = (cfg_width == 0) ? 1 : 32'(cfg_width);
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    was_first = first_row_q;
    if (!first_row_q) begin
      r = flatten_px(c, w, has_above_q, 1'b1, t.pixel_in);
      o.pixel_out = r;
      o.run_last  = 1'b0;
      run.push_back(o);
      upd_row[c] = r;
      left_px = r;
    end
    orig_row[c] = t.pixel_in;
    row_done = (c + 1 >= w);
    if (!row_done) begin
      col_cnt = c + 1;
    end else begin
      col_cnt = 0;
      if (first_row_q) first_row_q = 1'b0;
      else has_above_q = 1'b1;
    end
    if (t.frame_end && row_done) begin
      for (int unsigned j = 0; j < w; j++) begin
        r = flatten_px(j, w, !was_first, 1'b0, 8'd0);
        o.pixel_out = r;
        o.run_last  = 1'b0;
        run.push_back(o);
        left_px = r;
      end
      left_px = '0;
      col_cnt = 0;
      first_row_q = 1'b1;
      has_above_q = 1'b0;
    end
    for (int i = 0; i < run.size(); i++) begin
      o = run[i];
      o.run_last = (i == run.size() - 1);
      flat_q.push_back(o);
    end
  endfunction

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_gap    <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_pixel(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap    <= src_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          src_gap    <= $urandom_range(0, 4);
          in_valid_i <= 1'b0;
        end else if (raster_q.size() > 0) begin
          in_data_i  <= raster_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (flat_q.size() == 0) begin
          report($sformatf("unexpected transaction pixel_out=%0d", out_data_o.pixel_out));
        end else begin
          want = flat_q.pop_front();
          if (out_data_o.pixel_out !== want.pixel_out)
            report($sformatf("pixel_out got %0d want %0d",
                             out_data_o.pixel_out, want.pixel_out));
          if (out_data_o.run_last !== want.run_last)
            report($sformatf("run_last got %0b want %0b",
                             out_data_o.run_last, want.run_last));
        end
      end
      if (long_hold) begin
        out_ready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap    <= sink_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_gap    <= $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_px(input logic [7:0] p, input logic fe);
    in_t t;
    t.pixel_in  = p;
    t.frame_end = fe;
    raster_q.push_back(t);
    n_items++;
  endtask

  task automatic add_frame(input int unsigned w, input int unsigned rows,
                           input int unsigned noise);
    logic [7:0] base;
    logic [7:0] p;
    logic       fe;
    base = 8'($urandom_range(0, 255));
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        case ($urandom_range(0, 9))
          0:       p = 8'($urandom_range(0, 255));
          1:       p = 8'hFF;
          2:       p = 8'h00;
          default: p = base ^ 8'($urandom_range(0, 3));
        endcase
        fe = (r + 1 == rows && c + 1 == w) ||
             (c + 1 != w && $urandom_range(0, 99) < noise);
        push_px(p, fe);
      end
    end
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) cfg_width = val[5:0];
    else cfg_thr = val;
  endtask

  task automatic drain();
    while (raster_q.size() != 0 || in_valid_i || flat_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  initial begin
    int unsigned w;
    int unsigned thr;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // width 4: two rows with a stray frame_end mid-row, then a single-row frame
    write_cfg(CFG_IMAGE_WIDTH, 8'd4);
    write_cfg(CFG_SPIKE_THRESHOLD, 8'd0);
    push_px(8'd200, 1'b0); push_px(8'd10, 1'b1); push_px(8'd255, 1'b0); push_px(8'd0, 1'b0);
    push_px(8'd0, 1'b0); push_px(8'd255, 1'b0); push_px(8'd7, 1'b0); push_px(8'd255, 1'b1);
    push_px(8'd0, 1'b0); push_px(8'd255, 1'b0); push_px(8'd255, 1'b0); push_px(8'd128, 1'b1);
    drain();

    // one-pixel rows, max threshold: nothing joins
    write_cfg(CFG_IMAGE_WIDTH, 8'd1);
    write_cfg(CFG_SPIKE_THRESHOLD, 8'd255);
    push_px(8'd255, 1'b0); push_px(8'd0, 1'b0); push_px(8'd255, 1'b1);
    drain();

    // width 0 behaves as 1
    write_cfg(CFG_IMAGE_WIDTH, 8'd0);
    write_cfg(CFG_SPIKE_THRESHOLD, 8'd0);
    push_px(8'd0, 1'b0); push_px(8'd255, 1'b0); push_px(8'd1, 1'b1);
    drain();

    // widest rows, with the receiver held off long enough to back up the input
    write_cfg(CFG_IMAGE_WIDTH, 8'(MAX_WIDTH));
    write_cfg(CFG_SPIKE_THRESHOLD, 8'($urandom_range(0, 40)));
    hold_go = 1'b1;
    add_frame(MAX_WIDTH, 2, 5);
    drain();

    while (n_items < 156) begin
      w = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       thr = 0;
        1:       thr = $urandom_range(1, 15);
        2:       thr = $urandom_range(16, 254);
        default: thr = 255;
      endcase
      write_cfg(CFG_IMAGE_WIDTH, 8'(w));
      write_cfg(CFG_SPIKE_THRESHOLD, 8'(thr));
      repeat ($urandom_range(1, 3))
        add_frame((w == 0) ? 1 : w, $urandom_range(1, 5), 10);
      drain();
    end

    quiet <= 1'b1;
    write_cfg(CFG_IMAGE_WIDTH, 8'($urandom_range(2, 6)));
    write_cfg(CFG_SPIKE_THRESHOLD, 8'd3);
    add_frame(32'(cfg_width), 3, 0);
    add_frame(32'(cfg_width), 3, 0);
    drain();

    if (n_mismatch == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
